// File: sv/stpg_pkg.sv
// ----------------------------------------------------------------------------
// Step/direction pulse generator package
// Shared widths, queue sizing and the structs passed between the front end,
// the back end and the top level.
// ----------------------------------------------------------------------------
package stpg_pkg;

	localparam int COUNT_BITS    = 24;
	localparam int POSITION_BITS = 48;
	localparam int HALF_W        = 16;
	localparam int SETUP_W       = 8;
	localparam int MODE_W        = 3;
	localparam int PHASE_W       = 2;
	localparam int MAX_SHIFT     = 5;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	// Both internal queues are two entries deep.
	localparam int Q_DEPTH       = 2;
	localparam int Q_PTR_W       = 1;
	localparam int Q_CNT_W       = 2;

	typedef struct packed {
		logic                  is_move;
		logic                  neg;
		logic [COUNT_BITS-1:0] count;
		logic [COUNT_BITS-1:0] magnitude;
	} cmd_t;

	typedef struct packed {
		logic [HALF_W-1:0]  half_period_ticks;
		logic [SETUP_W-1:0] dir_setup_ticks;
		logic [MODE_W-1:0]  microstep_mode;
	} cfg_t;

	typedef struct packed {
		logic                     step_out;
		logic                     dir_out;
		logic [MODE_W-1:0]        mode_bits;
		logic                     busy_res;
		logic                     rejected;
		logic [POSITION_BITS-1:0] position;
	} res_t;

endpackage

// File: sv/stpg_front.sv
// ----------------------------------------------------------------------------
// Step/direction pulse generator front end
// Accepts input transactions, classifies them as ticks or moves, precomputes
// direction and step magnitude, and buffers them for the back end.
// ----------------------------------------------------------------------------
module stpg_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic                                   action,
	input  logic signed [stpg_pkg::COUNT_BITS-1:0] step_count,
	output logic                                   cmd_valid,
	output stpg_pkg::cmd_t                         cmd,
	input  logic                                   cmd_pop
);
	import stpg_pkg::*;

	cmd_t               cls;
	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               wr;
	logic               rd;

	always_comb begin
		cls.is_move = action;
		cls.neg     = step_count[COUNT_BITS-1];
		cls.count   = $unsigned(step_count);
		// The most negative count keeps its full magnitude as an unsigned value.
		if (step_count[COUNT_BITS-1]) begin
			cls.magnitude = ~$unsigned(step_count) + COUNT_BITS'(1);
		end else begin
			cls.magnitude = $unsigned(step_count);
		end
	end

	assign full      = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = mem_q[rd_ptr_q];
	assign wr        = push && !full;
	assign rd        = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/stpg_back.sv
// ----------------------------------------------------------------------------
// Step/direction pulse generator back end
// Runs the setup/high/low sequencer and the position counter for each
// command and queues one result per command for the output side.
// ----------------------------------------------------------------------------
module stpg_back (
	input  logic           clk,
	input  logic           arst_n,
	input  stpg_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	input  stpg_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           empty,
	input  logic           pop,
	output stpg_pkg::res_t res
);
	import stpg_pkg::*;

	localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
	localparam logic [PHASE_W-1:0] PH_SETUP = 2'd1;
	localparam logic [PHASE_W-1:0] PH_HIGH  = 2'd2;
	localparam logic [PHASE_W-1:0] PH_LOW   = 2'd3;

	logic [POSITION_BITS-1:0] position_q, position_d;
	logic [COUNT_BITS-1:0]    steps_q, steps_d;
	logic [HALF_W-1:0]        timer_q, timer_d;
	logic [PHASE_W-1:0]       phase_q, phase_d;
	logic                     dir_q, dir_d;
	logic                     level_q, level_d;
	logic                     rej_d;
	logic [HALF_W-1:0]        reload;
	logic [POSITION_BITS-1:0] ext;
	logic [POSITION_BITS-1:0] addend;
	logic                     cmd_take;
	res_t                     res_d;

	res_t               res_mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] res_wr_ptr_q;
	logic [Q_PTR_W-1:0] res_rd_ptr_q;
	logic [Q_CNT_W-1:0] res_cnt_q;
	logic               res_rd;

	assign cmd_take = cmd_valid && (res_cnt_q != Q_CNT_W'(Q_DEPTH));
	assign cmd_pop  = cmd_take;

	// A zero half period behaves like one tick.
	assign reload = (cfg.half_period_ticks == '0) ? '0 : cfg.half_period_ticks - 1'b1;

	// Position step is count * (32 >> mode); modes above five add nothing.
	assign ext = POSITION_BITS'($signed(cmd.count));
	always_comb begin
		if (cfg.microstep_mode <= MODE_W'(MAX_SHIFT)) begin
			addend = ext << (MODE_W'(MAX_SHIFT) - cfg.microstep_mode);
		end else begin
			addend = '0;
		end
	end

	always_comb begin
		position_d = position_q;
		steps_d    = steps_q;
		timer_d    = timer_q;
		phase_d    = phase_q;
		dir_d      = dir_q;
		level_d    = level_q;
		rej_d      = 1'b0;
		if (cmd.is_move) begin
			if (phase_q != PH_IDLE) begin
				rej_d = 1'b1;
			end else begin
				position_d = position_q + addend;
				dir_d      = !cmd.neg;
				steps_d    = cmd.magnitude;
				phase_d    = PH_SETUP;
				timer_d    = HALF_W'(cfg.dir_setup_ticks);
				level_d    = 1'b0;
			end
		end else if (phase_q != PH_IDLE) begin
			if (timer_q != '0) begin
				timer_d = timer_q - 1'b1;
			end else if (phase_q == PH_HIGH) begin
				phase_d = PH_LOW;
				level_d = 1'b0;
				timer_d = reload;
			end else if (steps_q != '0) begin
				steps_d = steps_q - 1'b1;
				phase_d = PH_HIGH;
				level_d = 1'b1;
				timer_d = reload;
			end else begin
				phase_d = PH_IDLE;
				level_d = 1'b0;
				timer_d = '0;
			end
		end
	end

	always_comb begin
		res_d.step_out  = level_d;
		res_d.dir_out   = dir_d;
		res_d.mode_bits = cfg.microstep_mode;
		res_d.busy_res  = (phase_d != PH_IDLE);
		res_d.rejected  = rej_d;
		res_d.position  = position_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			steps_q    <= '0;
			timer_q    <= '0;
			phase_q    <= PH_IDLE;
			dir_q      <= 1'b0;
			level_q    <= 1'b0;
		end else if (cmd_take) begin
			position_q <= position_d;
			steps_q    <= steps_d;
			timer_q    <= timer_d;
			phase_q    <= phase_d;
			dir_q      <= dir_d;
			level_q    <= level_d;
		end
	end

	// Result queue.
	assign empty  = (res_cnt_q == '0);
	assign res    = res_mem_q[res_rd_ptr_q];
	assign res_rd = pop && !empty;

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			res_mem_q[res_wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_ptr_q <= '0;
			res_rd_ptr_q <= '0;
			res_cnt_q    <= '0;
		end else begin
			if (cmd_take) begin
				res_wr_ptr_q <= (res_wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 :
					res_wr_ptr_q + 1'b1;
			end
			if (res_rd) begin
				res_rd_ptr_q <= (res_rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 :
					res_rd_ptr_q + 1'b1;
			end
			if (cmd_take && !res_rd) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (res_rd && !cmd_take) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_level_only_high: assert property (@(posedge clk) disable iff (!arst_n)
		level_q |-> (phase_q == PH_HIGH))
		else $error("step level high outside the high phase");

	a_idle_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (timer_q == '0))
		else $error("phase timer not clear while idle");

	a_move_starts_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && cmd.is_move && (phase_q == PH_IDLE)) |=> (phase_q == PH_SETUP))
		else $error("accepted move did not enter the setup phase");

	a_res_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("result queue count above its depth");
`endif

endmodule

// File: sv/stepper_step_dir_pulse_generator_core.sv
// A transaction is held in the input queue, then registered into the sequencer state and the
// result queue together, from which it can be popped. Throughput: one transaction per cycle
// while the result queue has room; the sequencer updates its state once per transaction.
// Two-entry queues on each side let input and output stall independently.
// Reset: arst_n clears position, sequencer and both queues at once; registers take defaults.
// ----------------------------------------------------------------------------
// Step/direction pulse generator core
// Drives a step/direction stepper driver from tick and move transactions,
// with a configuration write port for timing and microstep mode.
// ----------------------------------------------------------------------------
module stepper_step_dir_pulse_generator_core (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      push,
	output logic                                      full,
	input  logic                                      action,
	input  logic signed [stpg_pkg::COUNT_BITS-1:0]    step_count,
	output logic                                      empty,
	input  logic                                      pop,
	output logic                                      step_out,
	output logic                                      dir_out,
	output logic [stpg_pkg::MODE_W-1:0]               mode_bits,
	output logic                                      busy_res,
	output logic                                      rejected,
	output logic signed [stpg_pkg::POSITION_BITS-1:0] position,
	input  logic                                      wr_en,
	input  logic [stpg_pkg::CFG_IDX_W-1:0]            wr_index,
	input  logic [stpg_pkg::CFG_DATA_W-1:0]           wr_data
);
	import stpg_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_SETUP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEP   = 2'd2;

	localparam logic [HALF_W-1:0]  HALF_RESET  = 16'd100;
	localparam logic [SETUP_W-1:0] SETUP_RESET = 8'd35;
	localparam logic [MODE_W-1:0]  MODE_RESET  = 3'd0;

	logic [HALF_W-1:0]  half_q;
	logic [SETUP_W-1:0] setup_q;
	logic [MODE_W-1:0]  mode_q;
	cfg_t               cfg;
	logic               cmd_valid;
	logic               cmd_pop;
	cmd_t               cmd;
	res_t               res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q  <= HALF_RESET;
			setup_q <= SETUP_RESET;
			mode_q  <= MODE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_HALF_PERIOD: half_q  <= wr_data[HALF_W-1:0];
				CFG_DIR_SETUP:   setup_q <= wr_data[SETUP_W-1:0];
				CFG_MICROSTEP:   mode_q  <= wr_data[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.half_period_ticks = half_q;
		cfg.dir_setup_ticks   = setup_q;
		cfg.microstep_mode    = mode_q;
	end

	stpg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.step_count (step_count),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	stpg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign step_out  = res.step_out;
	assign dir_out   = res.dir_out;
	assign mode_bits = res.mode_bits;
	assign busy_res  = res.busy_res;
	assign rejected  = res.rejected;
	assign position  = $signed(res.position);

endmodule
